// ===== hdl/smx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, codes and sizes of the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int NUM_VARS    = 256;

    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 4;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int VAR_AW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int DEPTH_W = 9;

    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic [FUNC_W-1:0] OP_PUSH  = 4'd0;
    localparam logic [FUNC_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [FUNC_W-1:0] OP_SAVE  = 4'd2;
    localparam logic [FUNC_W-1:0] OP_ADD   = 4'd3;
    localparam logic [FUNC_W-1:0] OP_SUB   = 4'd4;
    localparam logic [FUNC_W-1:0] OP_MUL   = 4'd5;
    localparam logic [FUNC_W-1:0] OP_DIV   = 4'd6;
    localparam logic [FUNC_W-1:0] OP_EQ    = 4'd7;
    localparam logic [FUNC_W-1:0] OP_LT    = 4'd8;
    localparam logic [FUNC_W-1:0] OP_GT    = 4'd9;
    localparam logic [FUNC_W-1:0] OP_HALT  = 4'd10;

    localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_HALT   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_OVER   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_UNDER  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DIVZ   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_BADIDX = 3'd5;
    localparam logic [STAT_W-1:0] STAT_BADOP  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_ALU,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_DIV,
        ALU_FIX
    } alu_state_t;

    typedef struct packed {
        logic              start;
        logic [FUNC_W-1:0] op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/stack_machine_executor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack-machine instruction per input item and returns status,
// top of stack and depth. Halt and errors are sticky until reset.
//
//   channel  ports                              role
//   s_       s_valid s_ready s_func s_arg       instruction in
//   m_       m_valid m_ready m_status           result out
//            m_top_value m_depth
//
// push, halt, errors, frozen items and a store that empties the stack go
// straight to done; load and store pass a read state; binary ops a read
// and an ALU state (div one quotient bit a cycle in the shared unit).
// The stack memory read of the second operand sets the minimum for binary ops.
// Reset clears the stack count, status and the variable valid bits at once.
// A stalled result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module stack_machine_executor
    import smx_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [FUNC_W-1:0]  s_func,
    input  wire logic [WORD_W-1:0]  s_arg,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [STAT_W-1:0]       m_status,
    output logic [WORD_W-1:0]       m_top_value,
    output logic [DEPTH_W-1:0]      m_depth
);

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [WORD_W-1:0]   arg_reg, arg_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [NUM_VARS-1:0] var_valid_reg, var_valid_next;
    logic                var_hit_reg;
    logic                m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic [WORD_W-1:0]   m_top_reg, m_top_next;
    logic [DEPTH_W-1:0]  m_depth_reg, m_depth_next;

    logic                stk_we;
    logic [STK_AW-1:0]   stk_waddr;
    logic [WORD_W-1:0]   stk_wdata;
    logic [STK_AW-1:0]   stk_raddr;
    logic [WORD_W-1:0]   stk_rdata;
    logic                var_we;
    logic [VAR_AW-1:0]   var_idx;
    logic [WORD_W-1:0]   var_rdata;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    logic                full;
    logic                bad_idx;
    logic                out_free;

    assign full     = count_reg >= CNT_W'(STACK_DEPTH);
    assign bad_idx  = arg_reg[WORD_W-1] || (arg_reg >= WORD_W'(NUM_VARS));
    assign var_idx  = arg_reg[VAR_AW-1:0];
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                if (status_reg == STAT_OK) begin
                    case (func_reg)
                        OP_LOAD: begin
                            if (!bad_idx && !full) begin
                                state_next = S_READ;
                            end
                        end
                        OP_SAVE: begin
                            if (count_reg >= CNT_W'(2) && !bad_idx) begin
                                state_next = S_READ;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT: begin
                            if (count_reg >= CNT_W'(2)
                                && !(func_reg == OP_DIV && top_reg == '0)) begin
                                state_next = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (func_reg inside {[OP_ADD:OP_GT]}) begin
                    state_next = S_ALU;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        func_next      = func_reg;
        arg_next       = arg_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        status_next    = status_reg;
        var_valid_next = var_valid_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_top_next     = m_top_reg;
        m_depth_next   = m_depth_reg;
        stk_we         = 1'b0;
        stk_waddr      = count_reg[STK_AW-1:0];
        stk_wdata      = arg_reg;
        stk_raddr      = STK_AW'(count_reg - CNT_W'(2));
        var_we         = 1'b0;
        alu_req.start  = 1'b0;
        alu_req.op     = func_reg;
        alu_req.a      = stk_rdata;
        alu_req.b      = top_reg;
        s_ready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next = s_func;
                    arg_next  = s_arg;
                end
            end
            S_EXEC: begin
                if (status_reg == STAT_OK) begin
                    case (func_reg)
                        OP_PUSH: begin
                            if (full) begin
                                status_next = STAT_OVER;
                            end else begin
                                stk_we     = 1'b1;
                                top_next   = arg_reg;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_LOAD: begin
                            if (bad_idx) begin
                                status_next = STAT_BADIDX;
                            end else if (full) begin
                                status_next = STAT_OVER;
                            end
                        end
                        OP_SAVE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_UNDER;
                            end else if (bad_idx) begin
                                status_next = STAT_BADIDX;
                            end else begin
                                var_we                  = 1'b1;
                                var_valid_next[var_idx] = 1'b1;
                                count_next              = count_reg - 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT: begin
                            if (count_reg < CNT_W'(2)) begin
                                status_next = STAT_UNDER;
                            end else if (func_reg == OP_DIV && top_reg == '0) begin
                                status_next = STAT_DIVZ;
                            end
                        end
                        OP_HALT: status_next = STAT_HALT;
                        default: status_next = STAT_BADOP;
                    endcase
                end
            end
            S_READ: begin
                case (func_reg)
                    OP_LOAD: begin
                        stk_we     = 1'b1;
                        stk_wdata  = var_hit_reg ? var_rdata : '0;
                        top_next   = stk_wdata;
                        count_next = count_reg + 1'b1;
                    end
                    OP_SAVE: top_next = stk_rdata;
                    default:  alu_req.start = 1'b1;
                endcase
            end
            S_ALU: begin
                stk_waddr = STK_AW'(count_reg - CNT_W'(2));
                stk_wdata = alu_rsp.result;
                if (alu_rsp.done) begin
                    stk_we     = 1'b1;
                    top_next   = alu_rsp.result;
                    count_next = count_reg - 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_top_next    = (count_reg == '0) ? '0 : top_reg;
                    m_depth_next  = DEPTH_W'(count_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= STAT_OK;
            var_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            var_valid_reg <= var_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        func_reg     <= func_next;
        arg_reg      <= arg_next;
        top_reg      <= top_next;
        var_hit_reg  <= var_valid_reg[var_idx];
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
    end

    smx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    smx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_VARS)
    ) u_var_ram (
        .aclk  (aclk),
        .we    (var_we),
        .waddr (var_idx),
        .wdata (top_reg),
        .raddr (var_idx),
        .rdata (var_rdata)
    );

    smx_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_top_value = m_top_reg;
    assign m_depth     = m_depth_reg;

endmodule
`default_nettype wire

// ===== hdl/smx_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/smx_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smx_alu
// Shared arithmetic unit: add, sub, mul and compares with a registered result,
// signed truncating division one quotient bit a cycle.
// ----------------------------------------------------------------------------
module smx_alu
    import smx_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    alu_state_t        state_reg, state_next;
    logic [WORD_W:0]   rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] result_reg, result_next;
    logic              done_reg, done_next;

    logic [WORD_W-1:0] quick;
    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] trial;
    logic [WORD_W-1:0] abs_a, abs_b;

    always_comb begin
        case (req.op)
            OP_ADD:  quick = req.a + req.b;
            OP_SUB:  quick = req.a - req.b;
            OP_MUL:  quick = req.a * req.b;
            OP_EQ:   quick = WORD_W'(req.a == req.b);
            OP_LT:   quick = WORD_W'($signed(req.a) < $signed(req.b));
            OP_GT:   quick = WORD_W'($signed(req.a) > $signed(req.b));
            default: quick = '0;
        endcase
    end

    assign abs_a   = req.a[WORD_W-1] ? (~req.a + 1'b1) : req.a;
    assign abs_b   = req.b[WORD_W-1] ? (~req.b + 1'b1) : req.b;
    assign shifted = {rem_reg[WORD_W-1:0], quo_reg[WORD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ALU_IDLE: begin
                if (req.start && req.op == OP_DIV) begin
                    state_next = ALU_DIV;
                end
            end
            ALU_DIV: begin
                if (cnt_reg == DIV_CW'(DIV_STEPS - 1)) begin
                    state_next = ALU_FIX;
                end
            end
            ALU_FIX: state_next = ALU_IDLE;
            default: state_next = ALU_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            ALU_IDLE: begin
                if (req.start) begin
                    if (req.op == OP_DIV) begin
                        rem_next = '0;
                        quo_next = abs_a;
                        dvs_next = abs_b;
                        neg_next = req.a[WORD_W-1] ^ req.b[WORD_W-1];
                        cnt_next = '0;
                    end else begin
                        result_next = quick;
                        done_next   = 1'b1;
                    end
                end
            end
            ALU_DIV: begin
                rem_next = trial[WORD_W+1] ? shifted : trial[WORD_W:0];
                quo_next = {quo_reg[WORD_W-2:0], ~trial[WORD_W+1]};
                cnt_next = cnt_reg + 1'b1;
            end
            ALU_FIX: begin
                result_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                done_next   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ALU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule
`default_nettype wire
